// ===== hdl/rss_pkg.sv =====
// package: shared types and constants for the running sample statistics core
package rss_pkg;

  localparam int unsigned MaxSamplesDef  = 65536;
  localparam int unsigned SampleWidthDef = 24;
  localparam int unsigned FracBitsDef    = 12;

  localparam int unsigned SumW   = 40;
  localparam int unsigned SqW    = 62;
  localparam int unsigned CntW   = 17;
  localparam int unsigned SmpW   = 24;
  localparam int unsigned ProdW  = 81;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [SqW-1:0]         SqMax  = {SqW{1'b1}};

  // operation codes for the shared unit
  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT,
    OP_MUL
  } rss_op_e;

  typedef struct packed {
    logic    start;
    rss_op_e op;
  } rss_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_FRAME,
    ST_MEAN,
    ST_SQMUL,
    ST_SQOVER,
    ST_VAR,
    ST_SIGMA,
    ST_RMSDIV,
    ST_RMS,
    ST_OUT
  } rss_state_e;

endpackage

// ===== hdl/rss_alu.sv =====
// shared iterative unit: 81/64-bit divide, 64-bit square root or 40-bit shift-add multiply
module rss_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rss_pkg::rss_cmd_t   cmd_i,
  input  logic [80:0]         a_i,
  input  logic [63:0]         b_i,
  output logic                done_o,
  output logic [80:0]         res_o
);
  import rss_pkg::*;

  logic [80:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] b_q, b_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  rss_op_e     op_q, op_d;
  logic [64:0] trial;
  logic [65:0] rtrial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    trial  = '0;
    rtrial = '0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      quo_d  = (cmd_i.op == OP_MUL) ? '0 : a_i;
      rem_d  = (cmd_i.op == OP_MUL) ? 65'(a_i[SumW-1:0]) : '0;
      b_d    = b_i;
      cnt_d  = (cmd_i.op == OP_DIV) ? 7'd81 : (cmd_i.op == OP_MUL) ? 7'(SumW) : 7'd32;
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        // one quotient bit a step
        trial = {rem_q[63:0], quo_q[80]};
        quo_d = {quo_q[79:0], 1'b0};
        if (trial >= {1'b0, b_q}) begin
          rem_d    = trial - {1'b0, b_q};
          quo_d[0] = 1'b1;
        end else begin
          rem_d = trial;
        end
      end else if (op_q == OP_MUL) begin
        // multiplier bits from the top, product shifted and added
        quo_d = {quo_q[79:0], 1'b0} + (rem_q[SumW-1] ? 81'(b_q) : 81'd0);
        rem_d = {rem_q[63:0], 1'b0};
      end else begin
        // one root bit a step: quo holds remaining radicand, b holds root
        rtrial = {rem_q[63:0], quo_q[63:62]};
        quo_d  = {quo_q[80:64], quo_q[61:0], 2'b00};
        if (rtrial >= {b_q[63:0], 2'b01}) begin
          rem_d = 65'(rtrial - {b_q[63:0], 2'b01});
          b_d   = {b_q[62:0], 1'b1};
        end else begin
          rem_d = rtrial[64:0];
          b_d   = {b_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // done follows the last step so the result is already registered
  assign done_o = done_q;
  assign res_o  = (op_q == OP_SQRT) ? {17'd0, b_q} : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    b_q   <= b_d;
  end
endmodule

// ===== hdl/running_sample_statistics_core.sv =====
// Running sample statistics: per-sample accumulation and frame-end math.
// Each sample has its magnitude square registered, then is accumulated; the next is taken only after that.
// A last sample with two or more valid samples gives its result beat after four divides,
// a square and two roots on one shared unit plus the SQ, FRAME and OUT control states;
// with fewer valid samples after the rms root alone. Not ready meanwhile.
// A waiting result holds the next frame end until taken; reset (async, low) clears control and accumulators.
module running_sample_statistics_core #(
  parameter int unsigned MAX_SAMPLES  = rss_pkg::MaxSamplesDef,
  parameter int unsigned SAMPLE_WIDTH = rss_pkg::SampleWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [23:0]  sample_i,
  input  logic                sample_valid_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [23:0]  min_value_o,
  output logic signed [23:0]  max_value_o,
  output logic [22:0]         min_positive_o,
  output logic                positive_seen_o,
  output logic                any_valid_o,
  output logic [16:0]         valid_count_o,
  output logic [16:0]         total_count_o,
  output logic signed [39:0]  sum_total_o,
  output logic [61:0]         sum_squares_o,
  output logic signed [23:0]  mean_o,
  output logic [23:0]         sigma_o,
  output logic [23:0]         rms_o
);
  import rss_pkg::*;

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SAMPLES);

  rss_state_e state_q, state_d;

  logic signed [SmpW-1:0] s_q;
  logic                   v_q, l_q;
  logic [47:0]            sq_q;
  logic signed [SmpW-1:0] min_q, max_q;
  logic [SmpW-1:0]        minp_q;
  logic                   pos_q;
  logic [CntW-1:0]        vcnt_q, tcnt_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]         sqs_q;

  // frozen frame copy for the post-processing
  logic signed [SmpW-1:0] f_min_q, f_max_q;
  logic [22:0]            f_minp_q;
  logic                   f_pos_q;
  logic [CntW-1:0]        f_vcnt_q, f_tcnt_q;
  logic signed [SumW-1:0] f_sum_q;
  logic [SqW-1:0]         f_sqs_q;
  logic [SumW-1:0]        amag_q;
  logic [SmpW-1:0]        mean_q, sigma_q, rms_q;
  logic [63:0]            tmp_q;
  logic                   out_valid_q;

  rss_cmd_t    cmd;
  logic        alu_done;
  logic [80:0] alu_a, alu_res;
  logic [63:0] alu_b;
  logic        started_q;

  logic signed [SmpW-1:0] s_ext;
  logic [SmpW-1:0]        s_mag;
  logic signed [SumW:0]   sum_wide;
  logic [SqW:0]           sqs_wide;
  logic                   n_ge2;

  assign s_ext = SmpW'($signed(sample_i[SAMPLE_WIDTH-1:0]));
  assign s_mag = s_ext[SmpW-1] ? SmpW'(-s_ext) : s_ext;
  assign n_ge2 = f_vcnt_q >= CntW'(2);

  assign in_stall_o = (state_q != ST_IDLE);

  rss_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQ;
      ST_SQ:     state_d = l_q ? ST_FRAME : ST_IDLE;
      ST_FRAME:  if (!out_valid_q) state_d = (vcnt_q >= CntW'(2)) ? ST_MEAN : ST_RMS;
      ST_MEAN:   if (alu_done) state_d = ST_SQMUL;
      ST_SQMUL:  if (alu_done) state_d = ST_SQOVER;
      ST_SQOVER: if (alu_done) state_d = ST_VAR;
      ST_VAR:    if (alu_done) state_d = ST_SIGMA;
      ST_SIGMA:  if (alu_done) state_d = ST_RMSDIV;
      ST_RMSDIV: if (alu_done) state_d = ST_RMS;
      ST_RMS:    if (alu_done) state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit commands
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_DIV;
    alu_a     = '0;
    alu_b     = '0;
    unique case (state_q)
      ST_MEAN: begin
        cmd.start = !started_q;
        alu_a = 81'(amag_q) + 81'(f_vcnt_q >> 1);
        alu_b = 64'(f_vcnt_q);
      end
      ST_SQMUL: begin
        cmd.start = !started_q;
        cmd.op = OP_MUL;
        alu_a = 81'(amag_q);
        alu_b = 64'(amag_q);
      end
      ST_SQOVER: begin
        // the square is still held in the unit
        cmd.start = !started_q;
        alu_a = alu_res;
        alu_b = 64'(f_vcnt_q);
      end
      ST_VAR: begin
        cmd.start = !started_q;
        alu_a = 81'(tmp_q);
        alu_b = 64'(f_vcnt_q - CntW'(1));
      end
      ST_SIGMA: begin
        cmd.start = !started_q;
        cmd.op = OP_SQRT;
        alu_a = 81'(tmp_q);
      end
      ST_RMSDIV: begin
        cmd.start = !started_q;
        alu_a = 81'(f_sqs_q);
        alu_b = 64'(f_vcnt_q);
      end
      ST_RMS: begin
        cmd.start = !started_q;
        cmd.op = OP_SQRT;
        alu_a = n_ge2 ? 81'(tmp_q) : 81'(f_sqs_q);
      end
      default: cmd.start = 1'b0;
    endcase
  end

  always_comb begin
    sum_wide = (SumW+1)'(sum_q) + (SumW+1)'(s_q);
    sqs_wide = (SqW+1)'(sqs_q) + (SqW+1)'(sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_q <= '0; max_q <= '0; minp_q <= '0; pos_q <= 1'b0;
      vcnt_q <= '0; tcnt_q <= '0; sum_q <= '0; sqs_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) started_q <= 1'b0;
      else if (cmd.start) started_q <= 1'b1;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
      if (state_q == ST_SQ) begin
        if (tcnt_q < CntMax) tcnt_q <= tcnt_q + CntW'(1);
        if (v_q) begin
          if (vcnt_q == '0 || s_q < min_q) min_q <= s_q;
          if (vcnt_q == '0 || s_q > max_q) max_q <= s_q;
          if (s_q > 0 && (!pos_q || SmpW'(s_q) < minp_q)) begin
            minp_q <= SmpW'(s_q);
            pos_q  <= 1'b1;
          end
          if (sum_wide > (SumW+1)'(SumMax))      sum_q <= SumMax;
          else if (sum_wide < (SumW+1)'(SumMin)) sum_q <= SumMin;
          else                                   sum_q <= sum_wide[SumW-1:0];
          sqs_q <= sqs_wide[SqW] ? SqMax : sqs_wide[SqW-1:0];
          if (vcnt_q < CntMax) vcnt_q <= vcnt_q + CntW'(1);
        end
      end
      if (state_q == ST_FRAME && !out_valid_q) begin
        min_q <= '0; max_q <= '0; minp_q <= '0; pos_q <= 1'b0;
        vcnt_q <= '0; tcnt_q <= '0; sum_q <= '0; sqs_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      s_q  <= s_ext;
      v_q  <= sample_valid_i;
      l_q  <= last_i;
      sq_q <= 48'(s_mag) * 48'(s_mag);
    end
    if (state_q == ST_FRAME && !out_valid_q) begin
      f_min_q  <= min_q;
      f_max_q  <= max_q;
      f_minp_q <= pos_q ? minp_q[22:0] : '0;
      f_pos_q  <= pos_q;
      f_vcnt_q <= vcnt_q;
      f_tcnt_q <= tcnt_q;
      f_sum_q  <= sum_q;
      f_sqs_q  <= sqs_q;
      amag_q   <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
      mean_q   <= '0;
      sigma_q  <= SmpW'(max_q - min_q);
    end
    if (alu_done) begin
      unique case (state_q)
        ST_MEAN: begin
          if (alu_res > 81'h7FFFFF) mean_q <= f_sum_q[SumW-1] ? 24'h800000 : 24'h7FFFFF;
          else mean_q <= f_sum_q[SumW-1] ? SmpW'(-alu_res[SmpW-1:0]) : alu_res[SmpW-1:0];
        end
        ST_SQOVER: begin
          if (alu_res[80:64] != '0) tmp_q <= '0;
          else tmp_q <= (64'(f_sqs_q) > alu_res[63:0]) ? 64'(f_sqs_q) - alu_res[63:0] : '0;
        end
        ST_VAR:    tmp_q <= alu_res[63:0];
        ST_SIGMA:  sigma_q <= (alu_res[63:24] != '0) ? '1 : alu_res[23:0];
        ST_RMSDIV: tmp_q <= alu_res[63:0];
        ST_RMS:    rms_q <= (alu_res[63:24] != '0) ? '1 : alu_res[23:0];
        default:   tmp_q <= tmp_q;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign min_value_o     = f_min_q;
  assign max_value_o     = f_max_q;
  assign min_positive_o  = f_minp_q;
  assign positive_seen_o = f_pos_q;
  assign any_valid_o     = f_vcnt_q != '0;
  assign valid_count_o   = f_vcnt_q;
  assign total_count_o   = f_tcnt_q;
  assign sum_total_o     = f_sum_q;
  assign sum_squares_o   = f_sqs_q;
  assign mean_o          = mean_q;
  assign sigma_o         = sigma_q;
  assign rms_o           = rms_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !cmd.start) else $error("double unit start");
endmodule

// ===== tb/running_sample_statistics_core_test.sv =====
// testbench: running sample statistics core checked against a built-in predictor
`timescale 1ns / 100ps

module running_sample_statistics_core_test;
  import rss_pkg::*;

  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic signed [23:0] min_v;
    logic signed [23:0] max_v;
    logic [22:0]        min_pos;
    logic               pos_seen;
    logic               any_v;
    logic [16:0]        vcnt;
    logic [16:0]        tcnt;
    logic signed [39:0] sum;
    logic [61:0]        sumsq;
    logic signed [23:0] mean;
    logic [23:0]        sigma;
    logic [23:0]        rms;
  } stats_t;

  typedef struct {
    logic [23:0] smp;
    bit          sv;
    bit          lst;
    bit          typed;
    stats_t      want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] sample_i = '0;
  logic               sample_valid_i = 1'b0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  stats_t             dut_res;

  // frame accumulators of the predictor
  logic signed [23:0] lo_acc, hi_acc;
  logic [23:0]        minpos_acc;
  bit                 pos_acc;
  int unsigned        vcnt_acc, tcnt_acc;
  logic signed [39:0] sum_acc;
  logic [61:0]        sq_acc;

  stats_t      frame_stats_q[$];
  row_t        dir_tab[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  running_sample_statistics_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_value_o    (dut_res.min_v),
    .max_value_o    (dut_res.max_v),
    .min_positive_o (dut_res.min_pos),
    .positive_seen_o(dut_res.pos_seen),
    .any_valid_o    (dut_res.any_v),
    .valid_count_o  (dut_res.vcnt),
    .total_count_o  (dut_res.tcnt),
    .sum_total_o    (dut_res.sum),
    .sum_squares_o  (dut_res.sumsq),
    .mean_o         (dut_res.mean),
    .sigma_o        (dut_res.sigma),
    .rms_o          (dut_res.rms)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic clear_frame();
    lo_acc = '0; hi_acc = '0; minpos_acc = '0; pos_acc = 1'b0;
    vcnt_acc = 0; tcnt_acc = 0; sum_acc = '0; sq_acc = '0;
  endtask

  // folds one beat into the frame and, on last, yields the frame statistics
  task automatic fold_sample(input logic signed [23:0] s, input bit v, input bit l,
                             output stats_t r, output bit has);
    logic [63:0]  mag, sq, amag, qm, q, d, vr, sg, rt;
    logic [127:0] p;
    longint       t;
    longint unsigned n;
    bit           neg;
    has = 1'b0;
    r = '0;
    if (tcnt_acc < MaxSamplesDef) tcnt_acc++;
    if (v) begin
      mag = (s < 0) ? 64'(-longint'(s)) : 64'(longint'(s));
      sq = mag * mag;
      if (vcnt_acc == 0) begin
        lo_acc = s; hi_acc = s;
      end else begin
        if (s < lo_acc) lo_acc = s;
        if (s > hi_acc) hi_acc = s;
      end
      if (s > 0 && (!pos_acc || 24'(s) < minpos_acc)) begin
        minpos_acc = 24'(s);
        pos_acc = 1'b1;
      end
      t = longint'(sum_acc) + longint'(s);
      if (t > longint'(SumMax)) t = longint'(SumMax);
      if (t < longint'(SumMin)) t = longint'(SumMin);
      sum_acc = 40'(t);
      if (64'(sq_acc) > 64'(SqMax) - sq) sq_acc = SqMax;
      else sq_acc = 62'(64'(sq_acc) + sq);
      if (vcnt_acc < MaxSamplesDef) vcnt_acc++;
    end
    if (l) begin
      n = vcnt_acc;
      neg = sum_acc < 0;
      if (n >= 2) begin
        amag = neg ? 64'(-longint'(sum_acc)) : 64'(longint'(sum_acc));
        qm = (amag + n / 2) / n;
        if (qm > 64'h7FFFFF) qm = neg ? 64'h800000 : 64'h7FFFFF;
        r.mean = neg ? 24'(-qm) : 24'(qm);
        p = 128'(amag) * 128'(amag);
        p = p / n;
        q = (p > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
        d = (64'(sq_acc) > q) ? 64'(sq_acc) - q : 64'd0;
        vr = d / (n - 1);
        sg = root_floor(vr);
        rt = root_floor(64'(sq_acc) / n);
      end else begin
        r.mean = '0;
        sg = 64'(longint'(hi_acc) - longint'(lo_acc));
        rt = root_floor(64'(sq_acc));
      end
      r.sigma = (sg > 64'hFFFFFF) ? 24'hFFFFFF : sg[23:0];
      r.rms = (rt > 64'hFFFFFF) ? 24'hFFFFFF : rt[23:0];
      r.min_v = lo_acc;
      r.max_v = hi_acc;
      r.min_pos = pos_acc ? minpos_acc[22:0] : '0;
      r.pos_seen = pos_acc;
      r.any_v = vcnt_acc != 0;
      r.vcnt = 17'(vcnt_acc);
      r.tcnt = 17'(tcnt_acc);
      r.sum = sum_acc;
      r.sumsq = sq_acc;
      has = 1'b1;
      clear_frame();
    end
  endtask

  task automatic flag_mismatch(input string fld, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_cnt++;
    $display("mismatch %s: got %h want %h at %0t", fld, got, want, $realtime);
  endtask

  task automatic send_beat(input logic [23:0] s, input bit v, input bit l,
                           input bit typed, input stats_t want);
    stats_t pred;
    bit     has;
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= s;
    sample_valid_i <= v;
    last_i         <= l;
    do @(posedge clk_i); while (in_stall_o);
    fold_sample(s, v, l, pred, has);
    if (has) frame_stats_q.push_back(typed ? want : pred);
  endtask

  task automatic add_row(input logic [23:0] s, input bit v, input bit l);
    row_t rw;
    rw.smp = s; rw.sv = v; rw.lst = l; rw.typed = 1'b0; rw.want = '0;
    dir_tab.push_back(rw);
  endtask

  function automatic logic [23:0] rand_value();
    case ($urandom_range(5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(32)) - 24'd16;
      default: return 24'($urandom);
    endcase
  endfunction

  // receiver: random stall, checks each result beat against the oldest frame
  always @(posedge clk_i) begin
    stats_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_stats_q.size() == 0) begin
        flag_mismatch("unexpected beat", '0, '0);
      end else begin
        w = frame_stats_q.pop_front();
        if (dut_res.min_v !== w.min_v) flag_mismatch("min_value", dut_res.min_v, w.min_v);
        if (dut_res.max_v !== w.max_v) flag_mismatch("max_value", dut_res.max_v, w.max_v);
        if (dut_res.min_pos !== w.min_pos)
          flag_mismatch("min_positive", dut_res.min_pos, w.min_pos);
        if (dut_res.pos_seen !== w.pos_seen)
          flag_mismatch("positive_seen", dut_res.pos_seen, w.pos_seen);
        if (dut_res.any_v !== w.any_v) flag_mismatch("any_valid", dut_res.any_v, w.any_v);
        if (dut_res.vcnt !== w.vcnt) flag_mismatch("valid_count", dut_res.vcnt, w.vcnt);
        if (dut_res.tcnt !== w.tcnt) flag_mismatch("total_count", dut_res.tcnt, w.tcnt);
        if (dut_res.sum !== w.sum) flag_mismatch("sum_total", dut_res.sum, w.sum);
        if (dut_res.sumsq !== w.sumsq) flag_mismatch("sum_squares", dut_res.sumsq, w.sumsq);
        if (dut_res.mean !== w.mean) flag_mismatch("mean", dut_res.mean, w.mean);
        if (dut_res.sigma !== w.sigma) flag_mismatch("sigma", dut_res.sigma, w.sigma);
        if (dut_res.rms !== w.rms) flag_mismatch("rms", dut_res.rms, w.rms);
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 14);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    row_t        rw;
    int unsigned flen, vpct, sent;
    clear_frame();
    // frame with no valid sample: only the total counts
    rw = '{smp: 24'd0, sv: 1'b0, lst: 1'b1, typed: 1'b1, want: '0};
    rw.want.tcnt = 17'd1;
    dir_tab.push_back(rw);
    // one valid most negative sample: min = max, square 2^46, root 2^23
    rw = '{smp: 24'h800000, sv: 1'b1, lst: 1'b1, typed: 1'b1, want: '0};
    rw.want.min_v = 24'h800000; rw.want.max_v = 24'h800000;
    rw.want.any_v = 1'b1; rw.want.vcnt = 17'd1; rw.want.tcnt = 17'd1;
    rw.want.sum = -40'sd8388608; rw.want.sumsq = 62'h1 << 46;
    rw.want.rms = 24'h800000;
    dir_tab.push_back(rw);
    add_row(24'h7FFFFF, 1'b1, 1'b1);
    // first valid sample not positive, smallest positive found later
    add_row(24'd5, 1'b0, 1'b0);
    add_row(24'd0, 1'b1, 1'b0);
    add_row(-24'd3, 1'b1, 1'b0);
    add_row(24'd10, 1'b1, 1'b0);
    add_row(24'd4, 1'b1, 1'b1);
    // zero sum
    add_row(24'd1, 1'b1, 1'b0);
    add_row(-24'd1, 1'b1, 1'b1);
    // mean ties round away from zero
    add_row(24'd3, 1'b1, 1'b0);
    add_row(24'd0, 1'b1, 1'b1);
    add_row(-24'd3, 1'b1, 1'b0);
    add_row(24'd0, 1'b1, 1'b1);
    add_row(24'hFFFFFF, 1'b0, 1'b0);
    add_row(24'hFFFFFF, 1'b0, 1'b1);
    add_row(24'h7FFFFF, 1'b1, 1'b0);
    add_row(24'h800000, 1'b1, 1'b1);
    add_row(24'h7FFFFF, 1'b1, 1'b0);
    add_row(24'h7FFFFF, 1'b1, 1'b0);
    add_row(24'h7FFFFF, 1'b1, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].smp, dir_tab[i].sv, dir_tab[i].lst,
                                   dir_tab[i].typed, dir_tab[i].want);

    sent = 0;
    for (int f = 0; sent < 1030; f++) begin
      calm = (f >= 12 && f < 20);
      flen = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      vpct = ($urandom_range(5) == 0) ? $urandom_range(0, 40) : $urandom_range(70, 100);
      for (int k = 0; k < flen; k++) begin
        send_beat(rand_value(), $urandom_range(99) < vpct, k == flen - 1, 1'b0, '0);
        sent++;
      end
      if (f == 25) begin
        // hold the sender off until every frame has come back
        in_valid_i <= 1'b0;
        while (frame_stats_q.size() != 0) @(posedge clk_i);
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (frame_stats_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
